/* rtl/rbb_pkg.sv */
// shared types, constants and helpers for the range bucket bitmap block
// no dependencies; imported by rbb_div and range_bucket_bitmap
package rbb_pkg;

	// bitmap geometry
	localparam int MAP_BITS  = 64;
	localparam int HIT_W     = 64;
	localparam int IDX_W     = 6;
	localparam int POS_W     = IDX_W + 1;
	localparam logic [HIT_W-1:0] MAP_MASK = (MAP_BITS >= HIT_W) ? {HIT_W{1'b1}} :
		((HIT_W'(1) << MAP_BITS) - HIT_W'(1));
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAP_BITS - 1);

	// datapath widths
	localparam int SAMPLE_W = 32;
	localparam int COUNT_W  = 6;
	localparam int STEP_W   = 32;
	localparam int DIV_W    = 32;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_RANGE_START  = 2'd0,
		CFG_RANGE_END    = 2'd1,
		CFG_BUCKET_COUNT = 2'd2,
		CFG_STEP_SIZE    = 2'd3
	} cfg_reg_t;

	// register reset values
	localparam logic signed [SAMPLE_W-1:0] RANGE_START_RST  = 32'sd0;
	localparam logic signed [SAMPLE_W-1:0] RANGE_END_RST    = 32'sd62;
	localparam logic [COUNT_W-1:0]         BUCKET_COUNT_RST = 6'd62;
	localparam logic [STEP_W-1:0]          STEP_SIZE_RST    = 32'd1;

	// sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CLASSIFY,
		ST_DIVIDE,
		ST_FINISH
	} seq_state_t;

	// control into and status out of the shared divider
	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

	// saturate a bit position to the last bit of the map
	function automatic logic [IDX_W-1:0] sat_pos(input logic [POS_W-1:0] pos);
		logic [POS_W-1:0] p;
		p = (pos > POS_MAX) ? POS_MAX : pos;
		return p[IDX_W-1:0];
	endfunction

endpackage

/* rtl/rbb_div.sv */
// iterative restoring divider, one quotient bit per cycle
// depends on rbb_pkg; a zero divisor gives an all-ones quotient
module rbb_div (
	input  logic                     clk,
	input  logic                     arst_n,
	input  rbb_pkg::div_ctl_t        ctl,
	input  logic [rbb_pkg::DIV_W-1:0] dividend,
	input  logic [rbb_pkg::DIV_W-1:0] divisor,
	output rbb_pkg::div_sts_t        sts,
	output logic [rbb_pkg::DIV_W-1:0] quotient
);
	import rbb_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0]     rem_q;
	logic [DIV_W-1:0]     dq_q;
	logic [DIV_W-1:0]     dsr_q;
	logic [DIV_W:0]       trial;
	logic [DIV_W:0]       diff;
	logic                 fits;

	// shift one dividend bit into the partial remainder and try a subtract
	assign trial = {rem_q, dq_q[DIV_W-1]};
	assign diff  = trial - {1'b0, dsr_q};
	assign fits  = !diff[DIV_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q <= '0;
			dq_q  <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			dq_q  <= {dq_q[DIV_W-2:0], fits};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign quotient = dq_q;

	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |-> !busy_q)
		else $error("divider started while busy");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && $past(busy_q))
		else $error("divider done without a run");

endmodule

/* rtl/range_bucket_bitmap.sv */
// top level of the range bucket bitmap: config registers, sequencer, bitmap
// depends on rbb_pkg and instantiates rbb_div
//
// usage
//  - sample channel: sample_valid / sample_stall carry one signed 32-bit sample
//    per request; a request is taken when valid is high and stall is low
//  - result channel: result_valid / result_stall carry bit_index, first_hit
//    and hit_map; the receiver holds result_stall high to stall
//  - config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//    cfg_ready is always high, write only while the block is idle
//  - sequencing: an out-of-range sample goes from accept through ST_CLASSIFY
//    to ST_FINISH, an in-range sample also through ST_DIVIDE; there the 32-bit
//    restoring divider by step_size sets the pace, one quotient bit per cycle
//  - throughput: one sample at a time, the next request is taken once the
//    previous one has been written to the result register
//  - a finished result waits in the output register while the next sample
//    is accepted and worked on; the bitmap only updates when its result
//    moves into that register
//  - reset clears the bitmap and restores the register defaults
//    (start 0, end 62, count 62, step 1)
module range_bucket_bitmap (
	input  logic                              clk,
	input  logic                              arst_n,
	// sample requests
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic signed [rbb_pkg::SAMPLE_W-1:0] sample,
	// result requests
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [rbb_pkg::IDX_W-1:0]         bit_index,
	output logic                              first_hit,
	output logic [rbb_pkg::HIT_W-1:0]         hit_map,
	// configuration writes
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [rbb_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rbb_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import rbb_pkg::*;

	// configuration registers
	logic signed [SAMPLE_W-1:0] range_start_q;
	logic signed [SAMPLE_W-1:0] range_end_q;
	logic [COUNT_W-1:0]         bucket_count_q;
	logic [STEP_W-1:0]          step_size_q;

	// sequencer and working registers
	seq_state_t                 state_q, state_d;
	logic signed [SAMPLE_W-1:0] sample_q;
	logic [POS_W-1:0]           pos_q;
	logic [HIT_W-1:0]           occ_q;

	// result register
	logic                       result_valid_q;
	logic [IDX_W-1:0]           bit_index_q;
	logic                       first_hit_q;
	logic [HIT_W-1:0]           hit_map_q;

	// divider link
	div_ctl_t                   div_ctl;
	div_sts_t                   div_sts;
	logic [DIV_W-1:0]           quotient;

	// combinational controls
	logic                       take_sample;
	logic                       below_start;
	logic                       at_or_above_end;
	logic [SAMPLE_W:0]          diff_full;
	logic [COUNT_W-1:0]         lim;
	logic [IDX_W-1:0]           pos_sat;
	logic [HIT_W-1:0]           bit_onehot;
	logic                       out_free;
	logic                       emit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_start_q  <= RANGE_START_RST;
			range_end_q    <= RANGE_END_RST;
			bucket_count_q <= BUCKET_COUNT_RST;
			step_size_q    <= STEP_SIZE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				CFG_RANGE_START:  range_start_q  <= cfg_data;
				CFG_RANGE_END:    range_end_q    <= cfg_data;
				CFG_BUCKET_COUNT: bucket_count_q <= cfg_data[COUNT_W-1:0];
				CFG_STEP_SIZE:    step_size_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// range tests; below-start wins over at-or-above-end
	assign below_start     = sample_q < range_start_q;
	assign at_or_above_end = sample_q >= range_end_q;
	// exact 33-bit difference, fits 32 bits when in range
	assign diff_full = {sample_q[SAMPLE_W-1], sample_q} -
		{range_start_q[SAMPLE_W-1], range_start_q};

	// clamp limit for the in-range index
	assign lim = (bucket_count_q != '0) ? bucket_count_q - 1'b1 : '0;

	// bit decode of the saturated position
	assign pos_sat    = sat_pos(pos_q);
	assign bit_onehot = HIT_W'(1) << pos_sat;

	assign out_free = !result_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		take_sample   = 1'b0;
		div_ctl.start = 1'b0;
		emit          = 1'b0;
		sample_stall  = 1'b1;
		case (state_q)
			ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					take_sample = 1'b1;
					state_d     = ST_CLASSIFY;
				end
			end
			ST_CLASSIFY: begin
				if (below_start || at_or_above_end) begin
					state_d = ST_FINISH;
				end else begin
					div_ctl.start = 1'b1;
					state_d       = ST_DIVIDE;
				end
			end
			ST_DIVIDE: begin
				if (div_sts.done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// wait for the result register to drain
				if (out_free) begin
					emit    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// working datapath
	always_ff @(posedge clk) begin
		if (take_sample) begin
			sample_q <= sample;
		end
		if (state_q == ST_CLASSIFY) begin
			if (below_start) begin
				pos_q <= {1'b0, bucket_count_q};
			end else if (at_or_above_end) begin
				pos_q <= {1'b0, bucket_count_q} + 1'b1;
			end
		end
		if (state_q == ST_DIVIDE && div_sts.done) begin
			// clamp the quotient to the last in-range bucket
			if (quotient > DIV_W'(lim)) begin
				pos_q <= {1'b0, lim};
			end else begin
				pos_q <= quotient[POS_W-1:0];
			end
		end
	end

	// the divider loads the difference at the start edge
	rbb_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.dividend (diff_full[DIV_W-1:0]),
		.divisor  (step_size_q),
		.sts      (div_sts),
		.quotient (quotient)
	);

	// sticky bitmap and the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q          <= '0;
			result_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				occ_q          <= (occ_q | bit_onehot) & MAP_MASK;
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			bit_index_q <= pos_sat;
			first_hit_q <= (occ_q & bit_onehot) == '0;
			hit_map_q   <= (occ_q | bit_onehot) & MAP_MASK;
		end
	end

	assign result_valid = result_valid_q;
	assign bit_index    = bit_index_q;
	assign first_hit    = first_hit_q;
	assign hit_map      = hit_map_q;

	a_busy_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> sample_stall)
		else $error("sample request taken while busy");

	a_result_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == ST_FINISH))
		else $error("result raised outside finish");

	a_reported_bit_set: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid_q |-> hit_map_q[bit_index_q])
		else $error("reported bit not set in map");

	a_no_div_in_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !div_sts.busy)
		else $error("divider running while idle");

endmodule
